// ===== rtl/nts_pkg.sv =====
// ----------------------------------------------------------------------------
// nts_pkg
// Shared constants and the query token type for the nearest-timestamp store.
// ----------------------------------------------------------------------------
`default_nettype none

package nts_pkg;

    // Ring geometry
    localparam int DEPTH        = 16;
    localparam int SLOT_BITS    = $clog2(DEPTH);
    localparam int TIME_BITS    = 48;
    localparam int PAYLOAD_BITS = 32;

    // Result field widths
    localparam int MATCH_PAYLOAD_BITS = 32;
    localparam int MATCH_SLOT_BITS    = 4;

    // Stream packing
    localparam int IN_DATA_BITS  = ((TIME_BITS + PAYLOAD_BITS + 7) / 8) * 8;
    localparam int IN_PAD_BITS   = IN_DATA_BITS - TIME_BITS - PAYLOAD_BITS;
    localparam int OUT_RAW_BITS  = MATCH_PAYLOAD_BITS + TIME_BITS + MATCH_SLOT_BITS;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS  = OUT_DATA_BITS - OUT_RAW_BITS;

    // Reset value of the gap register (99999999 s in microseconds)
    localparam logic [TIME_BITS-1:0] MAX_GAP_RESET = 48'd99999999000000;

    // Item kinds carried on tuser
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Query token that walks the row of cells
    typedef struct packed {
        logic                    valid;
        logic [TIME_BITS-1:0]    qts;
        logic [TIME_BITS-1:0]    best_diff;
        logic [SLOT_BITS-1:0]    best_slot;
        logic [TIME_BITS-1:0]    best_time;
        logic [PAYLOAD_BITS-1:0] best_payload;
    } token_t;

endpackage

`default_nettype wire

// ===== rtl/nts_cell.sv =====
// ----------------------------------------------------------------------------
// nts_cell
// One ring slot: holds a record and updates the passing query token.
// ----------------------------------------------------------------------------
`default_nettype none

module nts_cell (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic [nts_pkg::SLOT_BITS-1:0]    cell_idx,
    input  wire logic                             wr_en,
    input  wire logic [nts_pkg::TIME_BITS-1:0]    wr_time,
    input  wire logic [nts_pkg::PAYLOAD_BITS-1:0] wr_payload,
    input  wire logic                             advance,
    input  wire nts_pkg::token_t                  tok_in,
    output nts_pkg::token_t                       tok_out
);

    logic [nts_pkg::TIME_BITS-1:0]    time_reg;
    logic [nts_pkg::PAYLOAD_BITS-1:0] payload_reg;
    nts_pkg::token_t                  tok_reg;
    nts_pkg::token_t                  tok_next;
    logic [nts_pkg::TIME_BITS-1:0]    diff;
    logic                             hit;

    // Stored record, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg    <= '0;
            payload_reg <= '0;
        end else if (wr_en) begin
            time_reg    <= wr_time;
            payload_reg <= wr_payload;
        end
    end

    // Absolute difference and strict compare against best so far
    always_comb begin
        diff = (time_reg >= tok_in.qts) ? (time_reg - tok_in.qts) : (tok_in.qts - time_reg);
        hit  = (diff < tok_in.best_diff);
    end

    // Token update; slot 0 always loads its record as the fallback answer
    always_comb begin
        tok_next = tok_in;
        if (hit) begin
            tok_next.best_diff = diff;
            tok_next.best_slot = cell_idx;
        end
        if (hit || (cell_idx == '0)) begin
            tok_next.best_time    = time_reg;
            tok_next.best_payload = payload_reg;
        end
    end

    // Hand the token on to the neighbor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else if (advance) begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ===== rtl/nearest_timestamp_ring_store.sv =====
// ----------------------------------------------------------------------------
// nearest_timestamp_ring_store
// Ring of timestamped records with a nearest-timestamp query scanned by a
// row of cells, one slot per cycle while no held result blocks the row.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake           Contents
//  s_       in   s_tvalid/s_tready   tuser: kind; tdata: timestamp, payload
//  m_       out  m_tvalid/m_tready   tdata: match_payload, match_timestamp,
//                                           match_slot
//  cfg_     in   cfg_we              cfg_wdata: max_gap
//
//  An add gives no result; the next item is taken at once.
//  A query goes through the head register, one cell per slot, then the
//  output register, where its result is shown.
//  One query is in the row at a time; s_tready is low until it has left it.
//  A held result stops the row once a query token has reached its end;
//  adds are taken while a result waits.
//  Reset (synchronous, aresetn low) clears all slots directly; no sweep.
//
`default_nettype none

module nearest_timestamp_ring_store (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // timestamp [47:0], payload [79:48]
    input  wire logic [nts_pkg::IN_DATA_BITS-1:0]     s_tdata,
    // kind [0]
    input  wire logic                                 s_tuser,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // match_payload [31:0], match_timestamp [79:32], match_slot [83:80]
    output logic [nts_pkg::OUT_DATA_BITS-1:0]         m_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    input  wire logic                                 cfg_we,
    input  wire logic [nts_pkg::TIME_BITS-1:0]        cfg_wdata
);

    logic [nts_pkg::TIME_BITS-1:0]    max_gap_reg;
    logic [nts_pkg::SLOT_BITS-1:0]    write_slot_reg;
    logic [nts_pkg::SLOT_BITS-1:0]    write_slot_next;
    logic                             busy_reg;
    nts_pkg::token_t                  head_reg;
    nts_pkg::token_t                  head_next;
    nts_pkg::token_t                  chain [nts_pkg::DEPTH+1];
    nts_pkg::token_t                  last_tok;
    logic [nts_pkg::DEPTH:0]          chain_valid;
    logic [nts_pkg::OUT_DATA_BITS-1:0] m_tdata_reg;
    logic                             m_tvalid_reg;
    logic                             in_accept;
    logic                             add_accept;
    logic                             query_accept;
    logic                             advance;
    logic                             done;
    logic [nts_pkg::TIME_BITS-1:0]    in_time;
    logic [nts_pkg::PAYLOAD_BITS-1:0] in_payload;

    // Input decode
    assign in_time      = s_tdata[nts_pkg::TIME_BITS-1:0];
    assign in_payload   = s_tdata[nts_pkg::TIME_BITS +: nts_pkg::PAYLOAD_BITS];
    assign s_tready     = !busy_reg;
    assign in_accept    = s_tvalid && s_tready;
    assign add_accept   = in_accept && (s_tuser == nts_pkg::KIND_ADD);
    assign query_accept = in_accept && (s_tuser == nts_pkg::KIND_QUERY);

    // Row moves unless a finished token is blocked by a held result
    assign last_tok = chain[nts_pkg::DEPTH];
    assign advance  = !(last_tok.valid && m_tvalid_reg && !m_tready);
    assign done     = last_tok.valid && advance;

    // Gap register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_gap_reg <= nts_pkg::MAX_GAP_RESET;
        end else if (cfg_we) begin
            max_gap_reg <= cfg_wdata;
        end
    end

    // Write pointer, wraps after the last slot
    always_comb begin
        if (write_slot_reg == nts_pkg::SLOT_BITS'(nts_pkg::DEPTH - 1)) begin
            write_slot_next = '0;
        end else begin
            write_slot_next = write_slot_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_slot_reg <= '0;
        end else if (add_accept) begin
            write_slot_reg <= write_slot_next;
        end
    end

    // Head of the row: a new query token starts with max_gap as best
    always_comb begin
        head_next = head_reg;
        if (query_accept) begin
            head_next              = '0;
            head_next.valid        = 1'b1;
            head_next.qts          = in_time;
            head_next.best_diff    = max_gap_reg;
        end else if (advance) begin
            head_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
        end else begin
            head_reg <= head_next;
        end
    end

    // Busy from query acceptance until its token leaves the row
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (query_accept) begin
            busy_reg <= 1'b1;
        end else if (done) begin
            busy_reg <= 1'b0;
        end
    end

    // Row of cells, one per slot
    assign chain[0] = head_reg;

    for (genvar i = 0; i < nts_pkg::DEPTH; i++) begin : g_cell
        nts_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cell_idx   (nts_pkg::SLOT_BITS'(i)),
            .wr_en      (add_accept && (write_slot_reg == nts_pkg::SLOT_BITS'(i))),
            .wr_time    (in_time),
            .wr_payload (in_payload),
            .advance    (advance),
            .tok_in     (chain[i]),
            .tok_out    (chain[i+1])
        );
    end

    for (genvar j = 0; j <= nts_pkg::DEPTH; j++) begin : g_valid
        assign chain_valid[j] = chain[j].valid;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            m_tdata_reg <= {{nts_pkg::OUT_PAD_BITS{1'b0}},
                            nts_pkg::MATCH_SLOT_BITS'(last_tok.best_slot),
                            last_tok.best_time,
                            nts_pkg::MATCH_PAYLOAD_BITS'(last_tok.best_payload)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(chain_valid) <= 1)
        else $error("more than one query token in the row");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (chain_valid == '0))
        else $error("token in the row while not busy");

    a_diff_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        last_tok.valid |-> (last_tok.best_diff <= max_gap_reg))
        else $error("best difference above max_gap");

    a_slot_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (last_tok.valid && (last_tok.best_slot != '0)) |-> (last_tok.best_diff < max_gap_reg))
        else $error("nonzero slot chosen without a qualifying difference");

endmodule

`default_nettype wire

// ===== verif/nts_match_checker.sv =====
// ----------------------------------------------------------------------------
// nts_match_checker
// Watches the add/query stream, the result stream and the gap register of the
// nearest-timestamp ring store. It keeps its own copy of the ring, predicts
// the nearest record for every accepted query, and compares each result
// transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module nts_match_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [nts_pkg::IN_DATA_BITS-1:0]  s_tdata,
    input  logic                              s_tuser,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [nts_pkg::OUT_DATA_BITS-1:0] m_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_we,
    input  logic [nts_pkg::TIME_BITS-1:0]     cfg_wdata,
    output int unsigned                       mismatches,
    output int unsigned                       outstanding
);
    import nts_pkg::*;

    localparam int PRINT_CAP = 100;

    typedef struct {
        logic [MATCH_PAYLOAD_BITS-1:0] payload;
        logic [TIME_BITS-1:0]          stamp;
        logic [MATCH_SLOT_BITS-1:0]    slot;
    } nearest_rec_t;

    // Shadow copy of the ring and the gap register
    logic [TIME_BITS-1:0]    ring_time    [DEPTH];
    logic [PAYLOAD_BITS-1:0] ring_payload [DEPTH];
    logic [SLOT_BITS-1:0]    next_slot;
    logic [TIME_BITS-1:0]    gap_limit;

    // Predicted results of accepted queries, oldest first
    nearest_rec_t pending_matches [$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] checker: %s", $time, msg);
    endtask

    // Scan from slot 0 up; a slot wins only if strictly closer than the best
    // so far, which starts at the gap limit. Nothing closer leaves slot 0.
    function automatic nearest_rec_t find_nearest(input logic [TIME_BITS-1:0] query_ts);
        nearest_rec_t         rec;
        logic [TIME_BITS-1:0] best_gap;
        logic [TIME_BITS-1:0] sep;
        int                   best;
        best     = 0;
        best_gap = gap_limit;
        for (int i = 0; i < DEPTH; i++) begin
            sep = (ring_time[i] >= query_ts) ? ring_time[i] - query_ts
                                             : query_ts - ring_time[i];
            if (sep < best_gap) begin
                best_gap = sep;
                best     = i;
            end
        end
        rec.payload = MATCH_PAYLOAD_BITS'(ring_payload[best]);
        rec.stamp   = ring_time[best];
        rec.slot    = MATCH_SLOT_BITS'(best);
        return rec;
    endfunction

    always @(posedge aclk) begin
        nearest_rec_t         got;
        nearest_rec_t         want;
        logic [TIME_BITS-1:0] in_stamp;
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                ring_time[i]    = '0;
                ring_payload[i] = '0;
            end
            next_slot = '0;
            gap_limit = MAX_GAP_RESET;
            pending_matches.delete();
        end else begin
            // Gap register write
            if (cfg_we)
                gap_limit = cfg_wdata;

            // Result transaction: compare against the oldest prediction
            if (m_tvalid && m_tready) begin
                got.payload = m_tdata[MATCH_PAYLOAD_BITS-1:0];
                got.stamp   = m_tdata[MATCH_PAYLOAD_BITS +: TIME_BITS];
                got.slot    = m_tdata[MATCH_PAYLOAD_BITS+TIME_BITS +: MATCH_SLOT_BITS];
                if (pending_matches.size() == 0) begin
                    report_mismatch($sformatf("result with no query waiting: tdata 0x%h",
                                              m_tdata));
                end else begin
                    want = pending_matches.pop_front();
                    if (got.payload !== want.payload)
                        report_mismatch($sformatf("match_payload expected 0x%h got 0x%h",
                                                  want.payload, got.payload));
                    if (got.stamp !== want.stamp)
                        report_mismatch($sformatf("match_timestamp expected 0x%h got 0x%h",
                                                  want.stamp, got.stamp));
                    if (got.slot !== want.slot)
                        report_mismatch($sformatf("match_slot expected %0d got %0d",
                                                  want.slot, got.slot));
                end
            end

            // Input transaction: store a record or predict a query
            if (s_tvalid && s_tready) begin
                in_stamp = s_tdata[TIME_BITS-1:0];
                if (s_tuser == KIND_QUERY) begin
                    pending_matches.push_back(find_nearest(in_stamp));
                end else begin
                    ring_time[next_slot]    = in_stamp;
                    ring_payload[next_slot] = s_tdata[TIME_BITS +: PAYLOAD_BITS];
                    next_slot = (next_slot == SLOT_BITS'(DEPTH - 1)) ? '0 : next_slot + 1'b1;
                end
            end
        end
        outstanding <= pending_matches.size();
    end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the nearest-timestamp ring store. A directed
// opening covers empty-ring queries, extreme stamps, ties, wrap of the write
// slot and a zero gap; random phases follow with changing gap settings,
// sender idling, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------

module testbench;
    import nts_pkg::*;

    localparam int DRAIN_CYCLES = DEPTH + 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 250000;

    logic                     aclk;
    logic                     aresetn   = 1'b0;
    logic [IN_DATA_BITS-1:0]  s_tdata   = '0;
    logic                     s_tuser   = KIND_ADD;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [TIME_BITS-1:0]     cfg_wdata = '0;

    int unsigned mismatches;
    int unsigned outstanding;

    // Stimulus shaping
    int unsigned          idle_pct   = 0;
    int unsigned          stall_pct  = 0;
    logic                 hold_start = 1'b0;
    logic                 hold_rx    = 1'b0;
    logic [TIME_BITS-1:0] anchor;
    logic [TIME_BITS-1:0] recent [$];
    int unsigned          cycles;

    nearest_timestamp_ring_store u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    nts_match_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Receiver: random stalls, or held low during the hold-off
    always @(posedge aclk) begin
        if (hold_rx)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99, 0) >= stall_pct);
    end

    // Long receiver hold-off, counted here while the sender keeps going
    initial begin
        wait (hold_start);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx <= 1'b0;
    end

    // Watchdog
    initial begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // One input transaction, with random idle cycles ahead of it
    task automatic send_item(input logic kind, input logic [TIME_BITS-1:0] stamp,
                             input logic [PAYLOAD_BITS-1:0] load);
        while ($urandom_range(99, 0) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= IN_DATA_BITS'({load, stamp});
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending, wait until every query has its result, then let adds settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_gap(input logic [TIME_BITS-1:0] value);
        wait_drained();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Stamps clustered near the anchor most often, plus wide, extreme and small ones
    function automatic logic [TIME_BITS-1:0] rand_stamp();
        int unsigned pick = $urandom_range(99, 0);
        logic [63:0] wide = {$urandom, $urandom};
        if (pick < 45)
            return anchor + $urandom_range(4000, 0);
        else if (pick < 75)
            return wide[TIME_BITS-1:0];
        else if (pick < 85)
            return $urandom_range(1, 0) ? '1 : '0;
        else
            return TIME_BITS'($urandom_range(65535, 0));
    endfunction

    task automatic run_random(input int count);
        logic [TIME_BITS-1:0] stamp;
        anchor = {16'($urandom_range(16'hFFFE, 0)), $urandom};
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99, 0) < 45) begin
                stamp = rand_stamp();
                // occasional duplicate stamp to force ties
                if (recent.size() != 0 && $urandom_range(9, 0) == 0)
                    stamp = recent[$urandom_range(recent.size() - 1, 0)];
                send_item(KIND_ADD, stamp, $urandom);
                recent.push_back(stamp);
                if (recent.size() > DEPTH)
                    void'(recent.pop_front());
            end else begin
                if (recent.size() != 0 && $urandom_range(99, 0) < 60)
                    stamp = recent[$urandom_range(recent.size() - 1, 0)]
                            + $urandom_range(80, 0) - 40;
                else
                    stamp = rand_stamp();
                send_item(KIND_QUERY, stamp, $urandom);
            end
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty ring: exact hit on slot 0, then nothing within the gap
        send_item(KIND_QUERY, '0, '1);
        send_item(KIND_QUERY, '1, '0);
        // Extreme stamps and payloads, then a tie between slots 2 and 3
        send_item(KIND_ADD, '1, '1);
        send_item(KIND_ADD, '0, '0);
        send_item(KIND_ADD, 48'd1000, 32'hA5A5_5A5A);
        send_item(KIND_ADD, 48'd3000, 32'h1234_5678);
        send_item(KIND_QUERY, 48'd2000, '0);
        send_item(KIND_QUERY, '1, '0);
        send_item(KIND_QUERY, {TIME_BITS{1'b1}} - 1'b1, '1);
        // Duplicate stamp: the lower slot wins
        send_item(KIND_ADD, 48'd3000, 32'hDEAD_BEEF);
        send_item(KIND_QUERY, 48'd3000, '0);
        // Fill the ring and wrap onto slot 0
        for (int i = 0; i < 12; i++)
            send_item(KIND_ADD, TIME_BITS'(5000 + 700 * i), 32'(i * 32'h0101_0101));
        send_item(KIND_QUERY, '1, '0);
        // Zero gap: nothing qualifies
        write_max_gap('0);
        send_item(KIND_QUERY, 48'd5700, '0);
        write_max_gap(MAX_GAP_RESET);

        // No idling, gap at its reset value
        run_random(200);

        // Sender idles often, widest gap
        idle_pct = 65;
        write_max_gap('1);
        run_random(190);

        // Receiver stalls often, zero gap
        idle_pct  = 0;
        stall_pct = 65;
        write_max_gap('0);
        run_random(150);

        // Both sides idle, narrow gap
        idle_pct  = 27;
        stall_pct = 27;
        write_max_gap(TIME_BITS'($urandom_range(3000, 1)));
        run_random(200);

        // Long receiver hold-off so the block backs up, wide random gap
        idle_pct  = 0;
        stall_pct = 0;
        write_max_gap({16'($urandom), $urandom});
        hold_start = 1'b1;
        run_random(220);

        // Both sides idle, exact matches only
        idle_pct  = 27;
        stall_pct = 27;
        write_max_gap(48'd1);
        run_random(190);

        wait_drained();
        if (mismatches == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
